// ===== hdl/scfr_pkg.sv =====
// Shared types and constants for the sum-checked frame receiver.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
`timescale 1ns / 1ps

package scfr_pkg;

	// Bytes of framing that the length field counts besides the payload.
	localparam logic [7:0] HEADER_OVERHEAD = 8'd4;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_DATA = 3'd3,
		PH_SUM  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_LEN_ERR = 2'd1,
		ST_SUM_ERR = 2'd2
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] frame_type;
		logic [7:0] payload_count;
		status_t    status;
	} result_t;

endpackage

// ===== hdl/scfr_parser.sv =====
// Frame parser: phase register, running checksum and header fields.
// Depends on scfr_pkg for the phase, status and result types.
`timescale 1ns / 1ps

module scfr_parser #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          start_byte,
	output logic                res_valid,
	output scfr_pkg::result_t   res
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD + 4);
	localparam logic [7:0] MAX_CNT = 8'(MAX_PAYLOAD);

	scfr_pkg::phase_t phase_q, phase_d;
	logic [7:0] running_sum_q, running_sum_d;
	logic [7:0] held_type_q, held_type_d;
	logic [7:0] held_count_q, held_count_d;
	logic [7:0] bytes_seen_q, bytes_seen_d;
	logic [8:0] seen_next;

	assign seen_next = {1'b0, bytes_seen_q} + 9'd1;

	always_comb begin
		phase_d       = phase_q;
		running_sum_d = running_sum_q;
		held_type_d   = held_type_q;
		held_count_d  = held_count_q;
		bytes_seen_d  = bytes_seen_q;
		res_valid     = 1'b0;
		res           = '0;
		unique case (phase_q)
			scfr_pkg::PH_HUNT: begin
				if (rx_byte == start_byte) begin
					phase_d = scfr_pkg::PH_LEN;
				end
			end
			scfr_pkg::PH_LEN: begin
				if (rx_byte > MAX_LEN) begin
					phase_d    = scfr_pkg::PH_HUNT;
					res_valid  = 1'b1;
					res.kind   = scfr_pkg::KIND_STATUS;
					res.status = scfr_pkg::ST_LEN_ERR;
				end else begin
					running_sum_d = rx_byte;
					held_count_d  = (rx_byte < scfr_pkg::HEADER_OVERHEAD) ? 8'd0 :
						rx_byte - scfr_pkg::HEADER_OVERHEAD;
					phase_d = scfr_pkg::PH_TYPE;
				end
			end
			scfr_pkg::PH_TYPE: begin
				held_type_d   = rx_byte;
				running_sum_d = running_sum_q + rx_byte;
				bytes_seen_d  = 8'd0;
				phase_d = (held_count_q == 8'd0) ? scfr_pkg::PH_SUM : scfr_pkg::PH_DATA;
			end
			scfr_pkg::PH_DATA: begin
				res_valid         = 1'b1;
				res.kind          = scfr_pkg::KIND_PAYLOAD;
				res.payload_byte  = rx_byte;
				res.payload_index = bytes_seen_q;
				res.frame_type    = held_type_q;
				res.payload_count = held_count_q;
				res.status        = scfr_pkg::ST_OK;
				running_sum_d     = running_sum_q + rx_byte;
				bytes_seen_d      = seen_next[7:0];
				if (seen_next >= {1'b0, held_count_q}) begin
					phase_d = scfr_pkg::PH_SUM;
				end
			end
			scfr_pkg::PH_SUM: begin
				res_valid         = 1'b1;
				res.kind          = scfr_pkg::KIND_STATUS;
				res.frame_type    = held_type_q;
				res.payload_count = held_count_q;
				res.status = (rx_byte == running_sum_q) ? scfr_pkg::ST_OK : scfr_pkg::ST_SUM_ERR;
				phase_d = scfr_pkg::PH_HUNT;
			end
			default: begin
				phase_d = scfr_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= scfr_pkg::PH_HUNT;
			running_sum_q <= 8'd0;
			held_type_q   <= 8'd0;
			held_count_q  <= 8'd0;
			bytes_seen_q  <= 8'd0;
		end else if (accept) begin
			phase_q       <= phase_d;
			running_sum_q <= running_sum_d;
			held_type_q   <= held_type_d;
			held_count_q  <= held_count_d;
			bytes_seen_q  <= bytes_seen_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= MAX_CNT)
		else $error("held payload count exceeds the maximum payload");

	a_seen_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == scfr_pkg::PH_DATA |-> bytes_seen_q < held_count_q)
		else $error("payload position reached the count while still in the data phase");

	a_sum_leads_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == scfr_pkg::PH_SUM |=> phase_q == scfr_pkg::PH_HUNT)
		else $error("checksum byte did not return the parser to hunting");
`endif

endmodule

// ===== hdl/scfr_out_buf.sv =====
// Two-entry output buffer: an output register backed by a skid register.
// Depends on scfr_pkg for the result type.
`timescale 1ns / 1ps

module scfr_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  scfr_pkg::result_t push_data,
	output logic              can_accept,
	output logic              out_valid,
	input  logic              out_ready,
	output scfr_pkg::result_t out_data
);

	logic              out_valid_q;
	logic              skid_valid_q;
	scfr_pkg::result_t out_data_q;
	scfr_pkg::result_t skid_data_q;
	logic              out_fire;

	assign out_fire   = out_valid_q && out_ready;
	assign can_accept = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_fire) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_valid_q || out_fire) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (!out_valid_q || out_fire) begin
				out_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("result pushed while both buffer entries are occupied");

	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_fire |=> out_valid_q && out_data_q == $past(skid_data_q))
		else $error("skid entry was not moved into the output register");
`endif

endmodule

// ===== hdl/sum_checked_frame_receiver.sv =====
// Top level of the sum-checked frame receiver.
// Depends on scfr_pkg, scfr_parser and scfr_out_buf.
`timescale 1ns / 1ps

// Usage:
// Received bytes arrive on rx_byte with in_valid/in_ready. Each accepted
// transaction advances the frame parser by one byte: it hunts for start_byte,
// then reads the length, the type, the payload and the checksum byte.
// Payload bytes and the end-of-frame status come out on out_valid/out_ready,
// one result per transaction at most; a length byte that is too large gives a
// length-error status, other hunting and header bytes give none. Throughput is
// one byte per cycle while in_ready is high, set by the combinational parser
// update between its state registers and the output register.
// When the receiver stalls, the output register holds its result and a skid
// register takes one more; in_ready falls only once both are occupied, and
// it depends on registered state alone, not on out_ready.
// The start_byte register is written through cfg_wr_en/cfg_wr_data and is
// meant to change only while no frame is in progress.
// Reset (arst_n low, asynchronous) returns the parser to hunting, clears the
// checksum and header fields, sets start_byte to zero and empties the buffer.
module sum_checked_frame_receiver #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic [7:0] payload_index,
	output logic [7:0] frame_type,
	output logic [7:0] payload_count,
	output logic [1:0] status
);

	logic [7:0]        start_byte_q;
	logic              in_fire;
	logic              res_valid;
	scfr_pkg::result_t res;
	scfr_pkg::result_t out_data;
	logic              can_accept;

	// The start byte is the only configuration register; writes never wait.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= 8'd0;
		end else if (cfg_wr_en) begin
			start_byte_q <= cfg_wr_data;
		end
	end

	assign in_ready = can_accept;
	assign in_fire  = in_valid && in_ready;

	// The parser looks at the byte on the input port and commits its state
	// update on the accepting edge; its result is pushed at that same edge.
	scfr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_fire),
		.rx_byte   (rx_byte),
		.start_byte(start_byte_q),
		.res_valid (res_valid),
		.res       (res)
	);

	scfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire && res_valid),
		.push_data (res),
		.can_accept(can_accept),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign kind          = out_data.kind;
	assign payload_byte  = out_data.payload_byte;
	assign payload_index = out_data.payload_index;
	assign frame_type    = out_data.frame_type;
	assign payload_count = out_data.payload_count;
	assign status        = out_data.status;

endmodule

// ===== dv/scfr_frame_checker.sv =====
// Result checker for the sum-checked frame receiver: follows the byte stream,
// predicts payload and end-of-frame results and compares them in order.
// Depends on scfr_pkg for the phase, status, kind and result types.
`timescale 1ns / 1ps

module scfr_frame_checker #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       kind,
	input  logic [7:0] payload_byte,
	input  logic [7:0] payload_index,
	input  logic [7:0] frame_type,
	input  logic [7:0] payload_count,
	input  logic [1:0] status,
	output int         mismatch_count,
	output int         results_pending
);

	import scfr_pkg::*;

	logic [7:0] marker;
	phase_t     parse_phase;
	logic [7:0] frame_sum;
	logic [7:0] type_held;
	logic [7:0] count_held;
	logic [7:0] seen_count;
	result_t    expected_results[$];

	// Moves the frame parser on by one received byte and queues any result.
	task advance_parser(input logic [7:0] b);
		result_t r;
		r = '0;
		case (parse_phase)
			PH_HUNT: begin
				if (b == marker)
					parse_phase = PH_LEN;
			end
			PH_LEN: begin
				if (int'(b) > MAX_PAYLOAD + int'(HEADER_OVERHEAD)) begin
					r.kind = KIND_STATUS;
					r.status = ST_LEN_ERR;
					expected_results.push_back(r);
					parse_phase = PH_HUNT;
				end else begin
					frame_sum = b;
					count_held = (b < HEADER_OVERHEAD) ? 8'd0 : b - HEADER_OVERHEAD;
					parse_phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_held = b;
				frame_sum = frame_sum + b;
				seen_count = 8'd0;
				parse_phase = (count_held == 8'd0) ? PH_SUM : PH_DATA;
			end
			PH_DATA: begin
				r.kind = KIND_PAYLOAD;
				r.payload_byte = b;
				r.payload_index = seen_count;
				r.frame_type = type_held;
				r.payload_count = count_held;
				r.status = ST_OK;
				expected_results.push_back(r);
				frame_sum = frame_sum + b;
				seen_count = seen_count + 8'd1;
				if (seen_count >= count_held)
					parse_phase = PH_SUM;
			end
			PH_SUM: begin
				r.kind = KIND_STATUS;
				r.frame_type = type_held;
				r.payload_count = count_held;
				r.status = (b == frame_sum) ? ST_OK : ST_SUM_ERR;
				expected_results.push_back(r);
				parse_phase = PH_HUNT;
			end
			default: begin
				parse_phase = PH_HUNT;
			end
		endcase
	endtask

	// Compares the result on the output port with the oldest prediction.
	task check_result();
		result_t want;
		bit      bad;
		if (expected_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: unexpected result kind %0d byte %02h index %0d type %02h count %0d status %0d",
					$time, kind, payload_byte, payload_index, frame_type, payload_count, status);
		end else begin
			want = expected_results.pop_front();
			bad = (kind !== want.kind) || (payload_byte !== want.payload_byte) ||
				(payload_index !== want.payload_index) || (frame_type !== want.frame_type) ||
				(payload_count !== want.payload_count) || (status !== want.status);
			if (bad) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: expected kind %0d byte %02h index %0d type %02h count %0d status %0d",
						$time, want.kind, want.payload_byte, want.payload_index,
						want.frame_type, want.payload_count, want.status);
					$display("%0t: actual   kind %0d byte %02h index %0d type %02h count %0d status %0d",
						$time, kind, payload_byte, payload_index, frame_type, payload_count, status);
				end
			end
		end
	endtask

	// Results leave before the byte of the same edge is parsed, since a byte's own
	// result is registered at its accepting edge and can only leave at a later edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker = 8'd0;
			parse_phase = PH_HUNT;
			frame_sum = 8'd0;
			type_held = 8'd0;
			count_held = 8'd0;
			seen_count = 8'd0;
			expected_results.delete();
			results_pending = 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (cfg_wr_en)
				marker = cfg_wr_data;
			if (in_valid && in_ready)
				advance_parser(rx_byte);
			results_pending = expected_results.size();
		end
	end

endmodule

// ===== dv/sum_checked_frame_receiver_tb.sv =====
// Testbench top for the sum-checked frame receiver: generates framed byte
// streams, start byte settings and handshake gaps, and reports the verdict.
// Depends on scfr_pkg, sum_checked_frame_receiver and scfr_frame_checker.
`timescale 1ns / 1ps

module sum_checked_frame_receiver_tb;

	import scfr_pkg::*;

	localparam int MAX_PAYLOAD = 32;
	// Length byte of a frame that carries the largest allowed payload.
	localparam int MAX_LENGTH = MAX_PAYLOAD + int'(HEADER_OVERHEAD);
	// Bytes of framed traffic sent with each start byte setting.
	localparam int PHASE_BYTES = 325;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       kind;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [7:0] frame_type;
	logic [7:0] payload_count;
	logic [1:0] status;

	int         mismatch_count;
	int         results_pending;

	// Start byte the block currently holds; frames are built around it.
	logic [7:0] active_start = 8'd0;
	// Burst modes: while set, the matching side never idles.
	bit         no_in_gaps = 1'b0;
	bit         no_out_stalls = 1'b0;
	// Bytes that belong to frames, used to size each random phase.
	int         frame_bytes_sent = 0;

	sum_checked_frame_receiver #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.frame_type   (frame_type),
		.payload_count(payload_count),
		.status       (status)
	);

	scfr_frame_checker #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.frame_type     (frame_type),
		.payload_count  (payload_count),
		.status         (status),
		.mismatch_count (mismatch_count),
		.results_pending(results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sends one byte as a transaction. An optional gap with valid low comes
	// first; then valid rises and stays up until the block takes the byte.
	// in_ready depends on registered state only, so sampling it at the falling
	// edge tells race-free whether the next rising edge accepts.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		bit took;
		gap = no_in_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Sends a whole frame: start byte, length, and unless the length is too
	// large, the type, the payload and the checksum. A negative fill gives
	// random payload bytes, otherwise every payload byte equals fill.
	task automatic send_frame(input logic [7:0] len, input logic [7:0] ftype,
		input bit bad_sum, input int fill);
		logic [7:0] running;
		logic [7:0] b;
		int         count;
		send_byte(active_start);
		send_byte(len);
		frame_bytes_sent += 2;
		if (int'(len) > MAX_LENGTH)
			return;
		count = (len < HEADER_OVERHEAD) ? 0 : int'(len - HEADER_OVERHEAD);
		running = len + ftype;
		send_byte(ftype);
		for (int i = 0; i < count; i++) begin
			b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
			running = running + b;
			send_byte(b);
		end
		// A nonzero offset guarantees that a corrupted checksum never matches.
		if (bad_sum)
			running = running + 8'($urandom_range(1, 255));
		send_byte(running);
		frame_bytes_sent += count + 2;
	endtask

	// Lowers valid and waits until every predicted result has come out. The guard
	// keeps a lost result from hanging the run; the leftover then shows up in the
	// verdict.
	task automatic wait_until_idle();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(negedge clk);
			guard++;
		end while (results_pending != 0 && guard < 5000);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start_byte(input logic [7:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		active_start = v;
	endtask

	// One random phase under a new start byte. Most traffic is well-formed
	// frames with random content; some frames carry a bad checksum, some a
	// length that is too large or too short, and now and then random noise
	// bytes arrive, which may themselves hit the start byte and misalign the
	// frame that follows.
	task automatic run_random_phase(input logic [7:0] marker_value);
		int         first_count;
		int         pick;
		logic [7:0] len;
		wait_until_idle();
		write_start_byte(marker_value);
		first_count = frame_bytes_sent;
		send_frame(8'(MAX_LENGTH), 8'($urandom_range(0, 255)), 1'b0, -1);
		while (frame_bytes_sent - first_count < PHASE_BYTES) begin
			if ($urandom_range(0, 15) == 0)
				no_in_gaps = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				pick = $urandom_range(0, 7);
				if (pick == 0)
					len = 8'($urandom_range(MAX_LENGTH + 1, 255));
				else if (pick == 1)
					len = 8'($urandom_range(0, int'(HEADER_OVERHEAD)));
				else
					len = 8'($urandom_range(int'(HEADER_OVERHEAD) + 1, MAX_LENGTH));
				send_frame(len, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, -1);
			end
		end
	endtask

	// Receiver side: before each result it may first hold out_ready low, then keeps
	// it high until a result is taken. Every forty results it may switch into a
	// burst stretch with no stalls at all.
	initial begin : receiver
		int stall;
		int served;
		bit got;
		served = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (served % 40 == 0)
				no_out_stalls = ($urandom_range(0, 3) == 0);
			stall = no_out_stalls ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				got = out_valid;
				@(posedge clk);
			end while (!got);
			served++;
		end
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset start byte of zero.
		// A byte other than the start byte is ignored while hunting.
		send_byte(8'h37);
		// Short length: no payload, checksum right after the type byte.
		send_frame(8'd0, 8'hFF, 1'b0, -1);
		// Length just above the largest allowed, then the largest byte value.
		send_frame(8'(MAX_LENGTH + 1), 8'h00, 1'b0, -1);
		send_frame(8'hFF, 8'h00, 1'b0, -1);
		// Exactly the header overhead with a wrong checksum.
		send_frame(HEADER_OVERHEAD, 8'h00, 1'b1, -1);
		// One all-ones payload byte; the checksum wraps around.
		send_frame(8'd5, 8'hAB, 1'b0, 255);
		// The start byte inside a frame is just payload.
		send_frame(8'd6, 8'h00, 1'b0, int'(active_start));

		// Random phases over several start bytes, both extremes included.
		run_random_phase(8'hFF);
		run_random_phase(8'h00);
		run_random_phase(8'($urandom_range(1, 254)));
		run_random_phase(8'($urandom_range(1, 254)));
		run_random_phase(8'($urandom_range(0, 255)));
		run_random_phase(8'h5A);

		wait_until_idle();
		if (mismatch_count == 0 && results_pending == 0)
			$display("sum_checked_frame_receiver_tb: PASS");
		else
			$display("sum_checked_frame_receiver_tb: FAIL");
		$finish;
	end

	// A correct run takes well under a millisecond of simulated time.
	initial begin : watchdog
		#5000000;
		$display("sum_checked_frame_receiver_tb: FAIL");
		$finish;
	end

endmodule
